/* design/mpq_pkg.sv */
// shared types and constants for the max priority queue
// no dependencies; used by mpq_ctrl and max_priority_queue_top
package mpq_pkg;

    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

endpackage

/* design/mpq_store.sv */
// entry store: priority and payload memories, one write and one read port
// read data is registered; no package dependency
module mpq_store #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32,
    parameter int PRIO_BITS    = 16,
    parameter int ADDR_W       = 4
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic [PRIO_BITS-1:0]    wr_prio,
    input  logic [PAYLOAD_BITS-1:0] wr_pay,
    input  logic [ADDR_W-1:0]       rd_addr,
    output logic [PRIO_BITS-1:0]    rd_prio,
    output logic [PAYLOAD_BITS-1:0] rd_pay
);

    logic [PRIO_BITS-1:0]    prio_mem [DEPTH];
    logic [PAYLOAD_BITS-1:0] pay_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prio_mem[wr_addr] <= wr_prio;
            pay_mem[wr_addr]  <= wr_pay;
        end
        rd_prio <= prio_mem[rd_addr];
        rd_pay  <= pay_mem[rd_addr];
    end

endmodule

/* design/mpq_ctrl.sv */
// sequencer: insert, max scan and compaction over the entry store, result register
// depends on mpq_pkg for status codes and op codes
module mpq_ctrl #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32,
    parameter int ADDR_W       = 4,
    parameter int CNT_W        = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_op,
    input  logic [mpq_pkg::PRIO_W-1:0]   in_prio,
    input  logic [PAYLOAD_BITS-1:0]      in_pay,
    output logic                         out_valid,
    input  logic                         out_ready,
    output mpq_pkg::status_t             out_status,
    output logic [mpq_pkg::PRIO_W-1:0]   out_prio,
    output logic [PAYLOAD_BITS-1:0]      out_pay,
    output logic [CNT_W-1:0]             out_cnt,
    output logic                         wr_en,
    output logic [ADDR_W-1:0]            wr_addr,
    output logic [mpq_pkg::PRIO_W-1:0]   wr_prio,
    output logic [PAYLOAD_BITS-1:0]      wr_pay,
    output logic [ADDR_W-1:0]            rd_addr,
    input  logic [mpq_pkg::PRIO_W-1:0]   rd_prio,
    input  logic [PAYLOAD_BITS-1:0]      rd_pay
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PUBLISH
    } state_t;

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [ADDR_W-1:0]            idx_reg, idx_next;
    logic [ADDR_W-1:0]            best_idx_reg, best_idx_next;
    logic [mpq_pkg::PRIO_W-1:0]   best_prio_reg, best_prio_next;
    logic [PAYLOAD_BITS-1:0]      best_pay_reg, best_pay_next;
    mpq_pkg::status_t             res_status_reg, res_status_next;
    logic                         out_valid_reg, out_valid_next;
    mpq_pkg::status_t             out_status_reg, out_status_next;
    logic [mpq_pkg::PRIO_W-1:0]   out_prio_reg, out_prio_next;
    logic [PAYLOAD_BITS-1:0]      out_pay_reg, out_pay_next;
    logic [CNT_W-1:0]             out_cnt_reg, out_cnt_next;

    logic             in_fire;
    logic             is_full;
    logic             idx_last;
    logic             take;
    logic [ADDR_W-1:0] scan_best;
    logic [CNT_W-1:0] count_m1;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign count_m1 = count_reg - CNT_W'(1);
    assign idx_last = (CNT_W'(idx_reg) == count_m1);
    // strictly greater keeps the oldest entry on ties
    assign take      = (idx_reg == '0) || (rd_prio > best_prio_reg);
    assign scan_best = take ? idx_reg : best_idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_pay_next   = best_pay_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_prio_next   = out_prio_reg;
        out_pay_next    = out_pay_reg;
        out_cnt_next    = out_cnt_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[ADDR_W-1:0];
        wr_prio         = in_prio;
        wr_pay          = in_pay;
        rd_addr         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    best_prio_next = '0;
                    best_pay_next  = '0;
                    state_next     = S_PUBLISH;
                    if (in_op == mpq_pkg::OP_INSERT)
                    begin
                        if (is_full)
                        begin
                            res_status_next = mpq_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                            res_status_next = mpq_pkg::ST_INSERTED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = mpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // entry 0 read now, arrives in the first scan cycle
                        res_status_next = mpq_pkg::ST_REMOVED;
                        idx_next        = '0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                best_idx_next = scan_best;
                if (take)
                begin
                    best_prio_next = rd_prio;
                    best_pay_next  = rd_pay;
                end
                if (!idx_last)
                begin
                    rd_addr  = idx_reg + ADDR_W'(1);
                    idx_next = idx_reg + ADDR_W'(1);
                end
                else if (CNT_W'(scan_best) != count_m1)
                begin
                    // start closing the gap behind the removed entry
                    rd_addr    = scan_best + ADDR_W'(1);
                    idx_next   = scan_best + ADDR_W'(1);
                    state_next = S_SHIFT;
                end
                else
                begin
                    count_next = count_m1;
                    state_next = S_PUBLISH;
                end
            end
            S_SHIFT:
            begin
                // write goes one below the read, so no address overlap
                wr_en   = 1'b1;
                wr_addr = idx_reg - ADDR_W'(1);
                wr_prio = rd_prio;
                wr_pay  = rd_pay;
                if (idx_last)
                begin
                    count_next = count_m1;
                    state_next = S_PUBLISH;
                end
                else
                begin
                    rd_addr  = idx_reg + ADDR_W'(1);
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end
            S_PUBLISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_prio_next   = best_prio_reg;
                    out_pay_next    = best_pay_reg;
                    out_cnt_next    = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            best_idx_reg   <= '0;
            best_prio_reg  <= '0;
            best_pay_reg   <= '0;
            res_status_reg <= mpq_pkg::ST_INSERTED;
            out_valid_reg  <= 1'b0;
            out_status_reg <= mpq_pkg::ST_INSERTED;
            out_prio_reg   <= '0;
            out_pay_reg    <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            best_idx_reg   <= best_idx_next;
            best_prio_reg  <= best_prio_next;
            best_pay_reg   <= best_pay_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_prio_reg   <= out_prio_next;
            out_pay_reg    <= out_pay_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_prio   = out_prio_reg;
    assign out_pay    = out_pay_reg;
    assign out_cnt    = out_cnt_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_op == mpq_pkg::OP_INSERT && !is_full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not bump entry count");

    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == mpq_pkg::ST_EMPTY) |-> out_cnt_reg == '0)
        else $error("empty status with nonzero count");

    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == mpq_pkg::ST_FULL)
        |-> out_cnt_reg == CNT_W'(DEPTH))
        else $error("full status with count below depth");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_PUBLISH) |-> !wr_en)
        else $error("store written outside insert or shift");

endmodule

/* design/max_priority_queue_top.sv */
// channel  dir  tdata (low bit up)                            tuser
// s_axis   in   priority_req[15:0], payload, zero pad           op
// m_axis   out  out_priority[15:0], out_payload, entry_count,   status
//               zero pad
//
// one item in flight at a time; every item gives one result item
// insert, full and empty cases go straight from idle to publish; a remove scans the
// stored entries with one store read per cycle, then, if the removed entry was not the last,
// does one read and one write per cycle to close the gap, set by the single read port
// reset clears the registers but not the store; the store needs no clearing pass
// a stalled result holds in the output register while the next item may be taken
//
// top level: stream packing around mpq_ctrl and mpq_store, uses mpq_pkg
module max_priority_queue_top #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // priority_req, payload, zero pad
    input  logic [((mpq_pkg::PRIO_W + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // op
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_priority, out_payload, entry_count, zero pad
    output logic [((mpq_pkg::PRIO_W + PAYLOAD_BITS + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                  m_tdata,
    // status
    output logic [mpq_pkg::STATUS_W-1:0] m_tuser
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int PW      = mpq_pkg::PRIO_W;
    localparam int OUT_RAW = PW + PAYLOAD_BITS + CNT_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [PW-1:0]           wr_prio;
    logic [PAYLOAD_BITS-1:0] wr_pay;
    logic [ADDR_W-1:0]       rd_addr;
    logic [PW-1:0]           rd_prio;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    mpq_pkg::status_t        out_status;
    logic [PW-1:0]           out_prio;
    logic [PAYLOAD_BITS-1:0] out_pay;
    logic [CNT_W-1:0]        out_cnt;

    mpq_store #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .PRIO_BITS    (PW),
        .ADDR_W       (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_prio (wr_prio),
        .wr_pay  (wr_pay),
        .rd_addr (rd_addr),
        .rd_prio (rd_prio),
        .rd_pay  (rd_pay)
    );

    mpq_ctrl #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .ADDR_W       (ADDR_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_prio    (s_tdata[PW-1:0]),
        .in_pay     (s_tdata[PW+PAYLOAD_BITS-1:PW]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_prio   (out_prio),
        .out_pay    (out_pay),
        .out_cnt    (out_cnt),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_prio    (wr_prio),
        .wr_pay     (wr_pay),
        .rd_addr    (rd_addr),
        .rd_prio    (rd_prio),
        .rd_pay     (rd_pay)
    );

    assign m_tdata = OUT_W'({out_cnt, out_pay, out_prio});
    assign m_tuser = out_status;

endmodule
